### design/pfa_pkg.sv
// Shared types, codes and helpers of the paged frame allocator.
`timescale 1ns / 1ps
package pfa_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_DECIDE,
        S_DEL_RD,
        S_DEL_FR,
        S_DEL_END,
        S_DIV,
        S_COUNT,
        S_PROBE,
        S_PWAIT,
        S_EMIT
    } t_state;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DUP       = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_NO_FRAMES = 3'd4;
    localparam logic [2:0] ST_LIMIT     = 3'd5;

    localparam logic MODE_DELETE = 1'b1;

    localparam logic CFG_FRAME_BYTES = 1'b0;
    localparam logic CFG_FRAMES      = 1'b1;

    localparam int DVD_W   = 24;
    localparam int DSR_W   = 16;
    localparam int WASTE_W = 22;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    function automatic logic [15:0] lfsr_next(input logic [15:0] v);
        logic [15:0] t;
        begin
            t = {1'b0, v[15:1]};
            if (v[0]) t = t ^ LFSR_TAPS;
            if (t == 16'd0) t = LFSR_SEED;
            return t;
        end
    endfunction

endpackage

### design/paged_frame_allocator.sv
// Top level of the paged frame allocator: process table, frame map and sequencer.
//
// channel  | direction | handshake          | payload
// request  | in        | i_valid / o_stall  | i_mode, i_process_id, i_process_bytes
// result   | out       | o_valid / i_stall  | o_status, o_frame_valid, o_frame_number,
//          |           |                    | o_last, o_total_fragmentation
// config   | in        | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// One request at a time; o_stall is high from acceptance until the last beat is taken.
// Table search scans every table entry; a delete reads and frees its frames one by one.
// An insert adds the size divide and a free count over all FRAMES entries,
// then probes of the shared divider (LFSR modulo active frames) until each needed frame is free.
// Synchronous active-low reset; no clearing pass. A stalled result beat holds.
`timescale 1ns / 1ps
module paged_frame_allocator
    import pfa_pkg::*;
#(
    parameter int FRAMES             = 128,
    parameter int PROCESSES          = 64,
    parameter int FRAMES_PER_PROCESS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic          i_mode,
    input  logic [15:0]   i_process_id,
    input  logic [23:0]   i_process_bytes,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [2:0]    o_status,
    output logic          o_frame_valid,
    output logic [6:0]    o_frame_number,
    output logic          o_last,
    output logic [21:0]   o_total_fragmentation,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [15:0]   i_cfg_data
);

    localparam int FW = $clog2(FRAMES);
    localparam int NW = $clog2(FRAMES + 1);
    localparam int PW = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int TW = $clog2(FRAMES_PER_PROCESS + 1);
    localparam int LD = PROCESSES * FRAMES_PER_PROCESS;
    localparam int LW = (LD > 1) ? $clog2(LD) : 1;
    localparam int EW = 32 + TW;

    t_state r_state, n_state;

    logic [15:0]        r_fbytes;
    logic [7:0]         r_frames;
    logic [FRAMES-1:0]  r_used, n_used;
    logic [PROCESSES-1:0] r_valid, n_valid;
    logic [WASTE_W-1:0] r_sum, n_sum;
    logic [15:0]        r_lfsr, n_lfsr;
    logic               r_oval, n_oval;

    logic               r_mode, n_mode;
    logic [15:0]        r_id, n_id;
    logic [23:0]        r_bytes, n_bytes;
    logic [PW:0]        r_idx, n_idx;
    logic               r_found, n_found;
    logic               r_slot_ok, n_slot_ok;
    logic [PW-1:0]      r_hit, n_hit;
    logic [PW-1:0]      r_free, n_free;
    logic [PW-1:0]      r_slot, n_slot;
    logic [15:0]        r_waste, n_waste;
    logic [TW-1:0]      r_total, n_total;
    logic [TW-1:0]      r_need, n_need;
    logic [TW-1:0]      r_k, n_k;
    logic [FW-1:0]      r_i, n_i;
    logic [NW-1:0]      r_cnt, n_cnt;
    logic [2:0]         r_status, n_status;
    logic               r_fv, n_fv;
    logic [6:0]         r_fnum, n_fnum;
    logic               r_last, n_last;

    logic [EW-1:0]      r_tbl [PROCESSES];
    logic [FW-1:0]      r_lst [LD];
    logic [EW-1:0]      tbl_rd;
    logic [FW-1:0]      lst_rd;
    logic               tbl_we, lst_we;
    logic [LW-1:0]      lst_addr;

    logic               div_start, div_done;
    logic [DVD_W-1:0]   div_dvd, div_q;
    logic [DSR_W-1:0]   div_dsr, div_r;

    logic [15:0]        fb;
    logic [NW-1:0]      act_n;
    logic [PW-1:0]      e_idx;
    logic               e_match, e_empty;
    logic [DVD_W:0]     w_need;
    logic               w_over;
    logic               cnt_add, cnt_fin;
    logic [NW-1:0]      cnt_nxt;
    logic [FW-1:0]      loc;
    logic               loc_used;
    logic [15:0]        w_waste;
    logic [15:0]        lfsr_step;

    pfa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dsr),
        .o_done     (div_done),
        .o_quot     (div_q),
        .o_rem      (div_r)
    );

    assign fb = (r_fbytes == 16'd0) ? 16'd1 : r_fbytes;

    always_comb begin
        if (r_frames == 8'd0)
            act_n = NW'(1);
        else if (16'(r_frames) > 16'(FRAMES))
            act_n = NW'(FRAMES);
        else
            act_n = NW'(r_frames);
    end

    assign e_idx   = PW'(r_idx - 1'b1);
    assign e_match = r_valid[e_idx] && (tbl_rd[EW-1 -: 16] == r_id) && !r_found;
    assign e_empty = !r_valid[e_idx] && !r_slot_ok;

    assign w_need  = {1'b0, div_q} + {{DVD_W{1'b0}}, (div_r != '0)};
    assign w_over  = w_need > (DVD_W + 1)'(FRAMES_PER_PROCESS);
    assign w_waste = (div_r != '0) ? (fb - div_r) : 16'd0;

    assign cnt_add = !r_used[r_i] && (16'(r_i) < 16'(act_n));
    assign cnt_nxt = r_cnt + NW'(cnt_add);
    assign cnt_fin = (r_i == FW'(FRAMES - 1));

    assign loc      = div_r[FW-1:0];
    assign loc_used = r_used[loc];
    assign lfsr_step = lfsr_next(r_lfsr);

    assign lst_addr = LW'(r_slot) * LW'(FRAMES_PER_PROCESS) + LW'(r_k);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (i_valid) n_state = S_SEARCH;
            S_SEARCH:  if (r_idx == (PW + 1)'(PROCESSES)) n_state = S_DECIDE;
            S_DECIDE: begin
                if (r_mode == MODE_DELETE) begin
                    if (!r_found)            n_state = S_EMIT;
                    else if (r_total == '0)  n_state = S_DEL_END;
                    else                     n_state = S_DEL_RD;
                end else if (r_found || !r_slot_ok) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DEL_RD:  n_state = S_DEL_FR;
            S_DEL_FR:  n_state = (r_k + 1'b1 == r_total) ? S_DEL_END : S_DEL_RD;
            S_DEL_END: n_state = S_EMIT;
            S_DIV: begin
                if (div_done) n_state = w_over ? S_EMIT : S_COUNT;
            end
            S_COUNT: begin
                if (cnt_fin) begin
                    if (16'(r_need) > 16'(cnt_nxt) || r_need == '0) n_state = S_EMIT;
                    else                                             n_state = S_PROBE;
                end
            end
            S_PROBE:   n_state = S_PWAIT;
            S_PWAIT: begin
                if (div_done) n_state = loc_used ? S_PROBE : S_EMIT;
            end
            S_EMIT: begin
                if (!i_stall) n_state = r_last ? S_IDLE : S_PROBE;
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_used    = r_used;
        n_valid   = r_valid;
        n_sum     = r_sum;
        n_lfsr    = r_lfsr;
        n_oval    = r_oval;
        n_mode    = r_mode;
        n_id      = r_id;
        n_bytes   = r_bytes;
        n_idx     = r_idx;
        n_found   = r_found;
        n_slot_ok = r_slot_ok;
        n_hit     = r_hit;
        n_free    = r_free;
        n_slot    = r_slot;
        n_waste   = r_waste;
        n_total   = r_total;
        n_need    = r_need;
        n_k       = r_k;
        n_i       = r_i;
        n_cnt     = r_cnt;
        n_status  = r_status;
        n_fv      = r_fv;
        n_fnum    = r_fnum;
        n_last    = r_last;
        tbl_we    = 1'b0;
        lst_we    = 1'b0;
        div_start = 1'b0;
        div_dvd   = DVD_W'(r_bytes);
        div_dsr   = fb;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_mode    = i_mode;
                    n_id      = i_process_id;
                    n_bytes   = i_process_bytes;
                    n_idx     = '0;
                    n_found   = 1'b0;
                    n_slot_ok = 1'b0;
                end
            end
            S_SEARCH: begin
                n_idx = r_idx + 1'b1;
                if (r_idx != '0) begin
                    if (e_match) begin
                        n_found = 1'b1;
                        n_hit   = e_idx;
                        n_waste = tbl_rd[TW +: 16];
                        n_total = tbl_rd[TW-1:0];
                    end
                    if (e_empty) begin
                        n_slot_ok = 1'b1;
                        n_free    = e_idx;
                    end
                end
            end
            S_DECIDE: begin
                n_status = ST_OK;
                n_fv     = 1'b0;
                n_fnum   = '0;
                n_last   = 1'b1;
                n_k      = '0;
                if (r_mode == MODE_DELETE) begin
                    n_slot = r_hit;
                    if (!r_found) begin
                        n_status = ST_NOT_FOUND;
                        n_oval   = 1'b1;
                    end
                end else if (r_found) begin
                    n_status = ST_DUP;
                    n_oval   = 1'b1;
                end else if (!r_slot_ok) begin
                    n_status = ST_FULL;
                    n_oval   = 1'b1;
                end else begin
                    n_slot    = r_free;
                    div_start = 1'b1;
                end
            end
            S_DEL_FR: begin
                n_used[lst_rd] = 1'b0;
                n_k            = r_k + 1'b1;
            end
            S_DEL_END: begin
                n_sum          = r_sum - WASTE_W'(r_waste);
                n_valid[r_slot] = 1'b0;
                n_oval         = 1'b1;
            end
            S_DIV: begin
                if (div_done) begin
                    n_need  = TW'(w_need);
                    n_waste = w_waste;
                    n_i     = '0;
                    n_cnt   = '0;
                    if (w_over) begin
                        n_status = ST_LIMIT;
                        n_oval   = 1'b1;
                    end
                end
            end
            S_COUNT: begin
                n_i   = r_i + 1'b1;
                n_cnt = cnt_nxt;
                if (cnt_fin) begin
                    if (16'(r_need) > 16'(cnt_nxt)) begin
                        n_status = ST_NO_FRAMES;
                        n_oval   = 1'b1;
                    end else begin
                        tbl_we          = 1'b1;
                        n_valid[r_slot] = 1'b1;
                        n_sum           = r_sum + WASTE_W'(r_waste);
                        if (r_need == '0) n_oval = 1'b1;
                    end
                end
            end
            S_PROBE: begin
                n_lfsr    = lfsr_step;
                div_start = 1'b1;
                div_dvd   = DVD_W'(lfsr_step);
                div_dsr   = DSR_W'(act_n);
            end
            S_PWAIT: begin
                if (div_done && !loc_used) begin
                    n_used[loc] = 1'b1;
                    lst_we      = 1'b1;
                    n_k         = r_k + 1'b1;
                    n_status    = ST_OK;
                    n_fv        = 1'b1;
                    n_fnum      = 7'(loc);
                    n_last      = (r_k + 1'b1 == r_need);
                    n_oval      = 1'b1;
                end
            end
            S_EMIT: begin
                if (!i_stall) n_oval = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fbytes <= 16'd4096;
            r_frames <= 8'd128;
            r_used   <= '0;
            r_valid  <= '0;
            r_sum    <= '0;
            r_lfsr   <= LFSR_SEED;
            r_oval   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_valid <= n_valid;
            r_sum   <= n_sum;
            r_lfsr  <= n_lfsr;
            r_oval  <= n_oval;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FRAME_BYTES: r_fbytes <= i_cfg_data;
                    CFG_FRAMES:      r_frames <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_id      <= n_id;
        r_bytes   <= n_bytes;
        r_idx     <= n_idx;
        r_found   <= n_found;
        r_slot_ok <= n_slot_ok;
        r_hit     <= n_hit;
        r_free    <= n_free;
        r_slot    <= n_slot;
        r_waste   <= n_waste;
        r_total   <= n_total;
        r_need    <= n_need;
        r_k       <= n_k;
        r_i       <= n_i;
        r_cnt     <= n_cnt;
        r_status  <= n_status;
        r_fv      <= n_fv;
        r_fnum    <= n_fnum;
        r_last    <= n_last;
    end

    // process table: id, waste, frame count
    always_ff @(posedge i_clk) begin
        if (tbl_we) r_tbl[r_slot] <= {r_id, r_waste, r_need};
        tbl_rd <= r_tbl[r_idx[PW-1:0]];
    end

    // per-process frame lists
    always_ff @(posedge i_clk) begin
        if (lst_we) r_lst[lst_addr] <= loc;
        lst_rd <= r_lst[lst_addr];
    end

    assign o_stall               = (r_state != S_IDLE);
    assign o_valid               = r_oval;
    assign o_status              = r_status;
    assign o_frame_valid         = r_fv;
    assign o_frame_number        = r_fnum;
    assign o_last                = r_last;
    assign o_total_fragmentation = r_sum;

endmodule

### design/pfa_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module pfa_div
    import pfa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DSR_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quot,
    output logic [DSR_W-1:0] o_rem
);

    localparam int CW = $clog2(DVD_W);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [DVD_W-1:0] r_q, n_q;
    logic [DSR_W:0]   r_r, n_r;
    logic [DSR_W-1:0] r_d, n_d;
    logic [DSR_W:0]   w_t;

    assign w_t = {r_r[DSR_W-1:0], r_q[DVD_W-1]};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_r    = r_r;
        n_d    = r_d;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(DVD_W - 1);
            n_q    = i_dividend;
            n_r    = '0;
            n_d    = i_divisor;
        end else if (r_busy) begin
            if (w_t >= {1'b0, r_d}) begin
                n_r = w_t - {1'b0, r_d};
                n_q = {r_q[DVD_W-2:0], 1'b1};
            end else begin
                n_r = w_t;
                n_q = {r_q[DVD_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_q   <= n_q;
        r_r   <= n_r;
        r_d   <= n_d;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r[DSR_W-1:0];

endmodule
